### sv/psplit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Path splitter package
// Shared character codes, byte classes, parser phases and the queue entry
// that passes a classified path beat from the front end to the back end.
// ----------------------------------------------------------------------------
package psplit_pkg;

  // Characters that the parser looks for.
  localparam logic [7:0] CHR_SLASH     = 8'h2F;
  localparam logic [7:0] CHR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHR_DOT       = 8'h2E;
  localparam logic [7:0] CHR_COLON     = 8'h3A;
  localparam logic [7:0] CHR_NUL       = 8'h00;

  // Width of the result beat: six 16-bit offsets and one flag, padded to bytes.
  localparam int unsigned RES_FIELD_BITS = 16;
  localparam int unsigned RES_DATA_BITS  = 104;

  // Class of one path byte.
  typedef enum logic [1:0] {
    CLS_OTHER = 2'd0,
    CLS_SEP   = 2'd1,
    CLS_ALPHA = 2'd2,
    CLS_DOT   = 2'd3
  } cls_t;

  // Where the parser stands within the root of the path.
  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_SECOND   = 3'd1,
    PH_DRIVE    = 3'd2,
    PH_UNC_SEPS = 3'd3,
    PH_UNC_NAME = 3'd4,
    PH_MAIN     = 3'd5
  } phase_t;

  // One classified beat as held in the queue.
  typedef struct packed {
    cls_t cls;
    logic is_colon;
    logic is_nul;
    logic has_byte;
    logic last;
  } q_entry_t;

endpackage

`default_nettype wire

### sv/psplit_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Path splitter front end
// Classifies each incoming path byte so that the back end only sees a byte
// class and a few marks.
// ----------------------------------------------------------------------------
module psplit_front (
  input  wire logic                 windows_mode,
  input  wire logic [7:0]           path_byte,
  input  wire logic                 has_byte,
  input  wire logic                 last,
  output      psplit_pkg::q_entry_t entry
);
  import psplit_pkg::*;

  logic is_sep;
  logic is_alpha;

  // Separator and letter tests; backslash only separates in Windows mode.
  assign is_sep   = (path_byte == CHR_SLASH) ||
                    (windows_mode && (path_byte == CHR_BACKSLASH));
  assign is_alpha = ((path_byte >= 8'h41) && (path_byte <= 8'h5A)) ||
                    ((path_byte >= 8'h61) && (path_byte <= 8'h7A));

  // Build the queue entry.
  always_comb begin
    if (is_sep) begin
      entry.cls = CLS_SEP;
    end else if (path_byte == CHR_DOT) begin
      entry.cls = CLS_DOT;
    end else if (is_alpha) begin
      entry.cls = CLS_ALPHA;
    end else begin
      entry.cls = CLS_OTHER;
    end
    entry.is_colon = (path_byte == CHR_COLON);
    entry.is_nul   = (path_byte == CHR_NUL);
    entry.has_byte = has_byte;
    entry.last     = last;
  end

endmodule

`default_nettype wire

### sv/psplit_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Path splitter queue
// Two-entry queue of classified beats between the front and back ends.
// ----------------------------------------------------------------------------
module psplit_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire psplit_pkg::q_entry_t push_data,
  output      logic                 full,
  input  wire logic                 pop,
  output      logic                 not_empty,
  output      psplit_pkg::q_entry_t pop_data
);
  import psplit_pkg::*;

  localparam logic [1:0] DEPTH = 2'd2;

  q_entry_t   mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full      = (count_r == DEPTH);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];

  // Entry storage; no reset needed on the payload.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### sv/psplit_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Path splitter back end
// Walks the classified beats through the root parser and the component
// tracker, and on the last beat of a path loads the result register.
// ----------------------------------------------------------------------------
module psplit_back #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  windows_mode,
  input  wire logic                                  q_valid,
  input  wire psplit_pkg::q_entry_t                  q_data,
  output      logic                                  q_pop,
  output      logic                                  out_tvalid,
  input  wire logic                                  out_tready,
  output      logic [psplit_pkg::RES_DATA_BITS-1:0]  out_tdata
);
  import psplit_pkg::*;

  localparam int unsigned OB = OFFSET_BITS;
  localparam logic [OB-1:0] OFF_MAX = '1;
  localparam logic [OB-1:0] OFF_ONE = OB'(1);
  localparam logic [OB-1:0] OFF_TWO = OB'(2);

  // Offsets found so far and the component tracking flags.
  typedef struct packed {
    logic [OB-1:0] root;
    logic [OB-1:0] dir;
    logic [OB-1:0] base;
    logic [OB-1:0] ext;
    logic [OB-1:0] name;
    logic [OB-1:0] last_dot;
    logic          f_in;
    logic          f_lead;
    logic          f_dot;
  } trk_t;

  // The root ends here: the directory, extension and name offsets restart from it, and the base is cleared.
  function automatic trk_t set_root(trk_t s, logic [OB-1:0] r);
    trk_t t;
    t      = s;
    t.root = r;
    t.dir  = r;
    t.base = '0;
    t.ext  = r;
    t.name = r;
    return t;
  endfunction

  // Close the current component at offset p.
  function automatic trk_t end_comp(trk_t s, logic [OB-1:0] p);
    trk_t          t;
    logic [OB-1:0] span;
    t      = s;
    span   = p - s.last_dot;
    t.name = p;
    if (s.f_dot && (span >= OFF_TWO)) begin
      t.ext = s.last_dot;
    end else begin
      t.ext = p;
    end
    t.f_in = 1'b0;
    return t;
  endfunction

  // One byte past the root.
  function automatic trk_t main_byte(trk_t s, logic [OB-1:0] p, cls_t cls);
    trk_t t;
    t = s;
    if (cls == CLS_SEP) begin
      if (s.f_in) begin
        t = end_comp(s, p);
      end
    end else begin
      if (!t.f_in) begin
        t.dir    = t.name;
        t.base   = p;
        t.f_in   = 1'b1;
        t.f_lead = 1'b1;
        t.f_dot  = 1'b0;
      end
      // Leading dots of a component never start an extension.
      if (!(t.f_lead && (cls == CLS_DOT))) begin
        t.f_lead = 1'b0;
        if (cls == CLS_DOT) begin
          t.last_dot = p;
          t.f_dot    = 1'b1;
        end
      end
    end
    return t;
  endfunction

  // Root of one byte in Windows mode: a separator or nothing.
  function automatic trk_t short_root(trk_t s, cls_t fbc);
    trk_t t;
    if (fbc == CLS_SEP) begin
      t = set_root(s, OFF_ONE);
    end else begin
      t = main_byte(set_root(s, '0), '0, fbc);
    end
    return t;
  endfunction

  trk_t          trk_r, trk_nxt, trk_fin;
  phase_t        phase_r, phase_nxt;
  cls_t          fbc_r, fbc_nxt;
  logic [OB-1:0] pos_r, pos_nxt;
  logic          done_r, done_nxt;
  logic          take;
  logic          need;
  logic          out_free;
  logic          res_valid_r;
  logic [RES_DATA_BITS-1:0] res_data_r, res_data;

  assign out_free   = !res_valid_r || out_tready;
  assign q_pop      = q_valid && (!q_data.last || out_free);
  assign out_tvalid = res_valid_r;
  assign out_tdata  = res_data_r;

  // Parser next state for the beat at the head of the queue.
  always_comb begin
    trk_nxt   = trk_r;
    phase_nxt = phase_r;
    fbc_nxt   = fbc_r;
    pos_nxt   = pos_r;
    done_nxt  = done_r;
    take      = q_data.has_byte && !done_r && (pos_r != OFF_MAX);
    if (take) begin
      if (q_data.is_nul) begin
        done_nxt = 1'b1;
      end else begin
        case (phase_r)
          PH_START: begin
            if (windows_mode) begin
              fbc_nxt   = q_data.cls;
              phase_nxt = PH_SECOND;
            end else if (q_data.cls == CLS_SEP) begin
              trk_nxt   = set_root(trk_r, OFF_ONE);
              phase_nxt = PH_MAIN;
            end else begin
              trk_nxt   = main_byte(set_root(trk_r, '0), pos_r, q_data.cls);
              phase_nxt = PH_MAIN;
            end
          end
          PH_SECOND: begin
            if ((fbc_r == CLS_SEP) && (q_data.cls == CLS_SEP)) begin
              phase_nxt = PH_UNC_SEPS;
            end else if ((fbc_r == CLS_ALPHA) && q_data.is_colon) begin
              phase_nxt = PH_DRIVE;
            end else begin
              trk_nxt   = main_byte(short_root(trk_r, fbc_r), pos_r, q_data.cls);
              phase_nxt = PH_MAIN;
            end
          end
          PH_DRIVE: begin
            if (q_data.cls == CLS_SEP) begin
              trk_nxt = set_root(trk_r, pos_r + OFF_ONE);
            end else begin
              trk_nxt = main_byte(set_root(trk_r, pos_r), pos_r, q_data.cls);
            end
            phase_nxt = PH_MAIN;
          end
          PH_UNC_SEPS: begin
            if (q_data.cls != CLS_SEP) begin
              phase_nxt = PH_UNC_NAME;
            end
          end
          PH_UNC_NAME: begin
            if (q_data.cls == CLS_SEP) begin
              trk_nxt   = set_root(trk_r, pos_r + OFF_ONE);
              phase_nxt = PH_MAIN;
            end
          end
          PH_MAIN: begin
            trk_nxt = main_byte(trk_r, pos_r, q_data.cls);
          end
          default: begin
            trk_nxt = trk_r;
          end
        endcase
        pos_nxt = pos_r + OFF_ONE;
      end
    end
  end

  // Result of a path that ends with this beat.
  always_comb begin
    case (phase_nxt)
      PH_START:  trk_fin = set_root(trk_nxt, '0);
      PH_SECOND: trk_fin = short_root(trk_nxt, fbc_nxt);
      PH_MAIN:   trk_fin = trk_nxt;
      default:   trk_fin = set_root(trk_nxt, pos_nxt);
    endcase
    if (pos_nxt == '0) begin
      need = 1'b1;
    end else begin
      need = (trk_fin.root != pos_nxt) && trk_fin.f_in;
    end
    if (trk_fin.f_in) begin
      trk_fin = end_comp(trk_fin, pos_nxt);
    end
    res_data = {7'd0, need,
                RES_FIELD_BITS'(pos_nxt),
                RES_FIELD_BITS'(trk_fin.name),
                RES_FIELD_BITS'(trk_fin.ext),
                RES_FIELD_BITS'(trk_fin.base),
                RES_FIELD_BITS'(trk_fin.dir),
                RES_FIELD_BITS'(trk_fin.root)};
  end

  // Parser state; a finished path leaves it cleared for the next one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_r   <= '0;
      phase_r <= PH_START;
      fbc_r   <= CLS_OTHER;
      pos_r   <= '0;
      done_r  <= 1'b0;
    end else if (q_pop) begin
      if (q_data.last) begin
        trk_r   <= '0;
        phase_r <= PH_START;
        fbc_r   <= CLS_OTHER;
        pos_r   <= '0;
        done_r  <= 1'b0;
      end else begin
        trk_r   <= trk_nxt;
        phase_r <= phase_nxt;
        fbc_r   <= fbc_nxt;
        pos_r   <= pos_nxt;
        done_r  <= done_nxt;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (q_pop && q_data.last) begin
      res_valid_r <= 1'b1;
    end else if (out_tready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.last) begin
      res_data_r <= res_data;
    end
  end

endmodule

`default_nettype wire

### sv/path_component_splitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Path component splitter
// Takes a path one byte a beat and returns its root, directory, basename,
// extension and name offsets on the beat marked last.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  in_*     slave      one path byte a beat, byte-present flag, end of path
//  out_*    master     one result beat per path
//  cfg_*    write      windows_mode register
//
// One beat is taken every cycle while in_tready is high. in_tready drops only
// when both queue entries are held, which happens while a last beat waits at
// the head of the queue for an untaken result to leave the result register.
// A result is shown after the last beat of its path is taken: the beat is
// written into the queue, waits at its head until the result register is
// free, and is then parsed into the result register.
// Reset is synchronous and clears the queue, the parser and the result.
// ----------------------------------------------------------------------------
module path_component_splitter #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Configuration.
  input  wire logic         cfg_we,
  input  wire logic         cfg_wdata,    // windows_mode
  // Input channel.
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  input  wire logic [7:0]   in_tdata,     // path_byte[7:0]
  input  wire logic         in_tuser,     // has_byte
  input  wire logic         in_tlast,     // last
  // Result channel.
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  output      logic [103:0] out_tdata     // root_end[15:0], dir_end[31:16],
                                          // base_start[47:32], ext_start[63:48],
                                          // name_end[79:64], path_length[95:80],
                                          // needs_separator[96], zero[103:97]
);
  import psplit_pkg::*;

  logic     windows_mode_r;
  q_entry_t front_entry;
  q_entry_t head_entry;
  logic     q_full;
  logic     q_not_empty;
  logic     q_pop;

  // Mode register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      windows_mode_r <= 1'b0;
    end else if (cfg_we) begin
      windows_mode_r <= cfg_wdata;
    end
  end

  assign in_tready = !q_full;

  psplit_front u_front (
    .windows_mode (windows_mode_r),
    .path_byte    (in_tdata),
    .has_byte     (in_tuser),
    .last         (in_tlast),
    .entry        (front_entry)
  );

  psplit_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid && in_tready),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (head_entry)
  );

  psplit_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .windows_mode (windows_mode_r),
    .q_valid      (q_not_empty),
    .q_data       (head_entry),
    .q_pop        (q_pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

endmodule

`default_nettype wire

### sv/psplit_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Path splitter port checker
// Watches the result channel of the splitter and is bound to its top level.
// ----------------------------------------------------------------------------
module psplit_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [103:0] out_tdata
);

  // A stalled result beat stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat withdrawn while stalled");

  // A stalled result beat keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result payload changed while stalled");

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // An empty path has every offset at zero and asks for a separator.
  a_empty_path: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[95:80] == 16'd0) |->
      out_tdata[96] && (out_tdata[79:0] == 80'd0))
    else $error("empty path gave a wrong result");

endmodule

bind path_component_splitter psplit_checker u_psplit_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

### verif/path_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path splitter result checker
// Watches the configuration port and both stream channels of the path
// component splitter. It keeps its own copy of the parser state, works out
// the split offsets for every path that ends, and compares each result beat
// field by field with the oldest offsets still waiting.
// ----------------------------------------------------------------------------
module path_checker
  import psplit_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic         cfg_wdata,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [7:0]   in_tdata,
  input  wire logic         in_tuser,
  input  wire logic         in_tlast,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [103:0] out_tdata,
  output int                fail_count,
  output int                pending,
  output int                splits_checked
);

  // Bytes at or past this offset are dropped and the count saturates.
  localparam int unsigned POS_LIMIT = 65535;

  // Slots of the offset table.
  localparam int IX_ROOT = 0;
  localparam int IX_DIR  = 1;
  localparam int IX_BASE = 2;
  localparam int IX_EXT  = 3;
  localparam int IX_NAME = 4;

  string field_names [8] = '{"root_end", "dir_end", "base_start", "ext_start",
                             "name_end", "path_length", "needs_separator",
                             "padding"};

  // Shadow of the parser.
  logic        win_mode;
  int unsigned pos;
  int unsigned dot_pos;
  int unsigned offs [5];
  phase_t      ph;
  cls_t        first_cls;
  logic        in_comp;
  logic        in_lead;
  logic        dot_seen;
  logic        nul_seen;

  // Split offsets still waiting for their result beat, packed as on out_tdata.
  logic [103:0] split_q [$];

  function automatic void clear_path();
    pos       = 0;
    dot_pos   = 0;
    ph        = PH_START;
    first_cls = CLS_OTHER;
    for (int i = 0; i < 5; i++) offs[i] = 0;
    in_comp   = 1'b0;
    in_lead   = 1'b0;
    dot_seen  = 1'b0;
    nul_seen  = 1'b0;
  endfunction

  function automatic cls_t classify(logic [7:0] b);
    if (b == CHR_SLASH || (win_mode && b == CHR_BACKSLASH)) return CLS_SEP;
    if (b == CHR_DOT) return CLS_DOT;
    if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) return CLS_ALPHA;
    return CLS_OTHER;
  endfunction

  // Fixing the root resets the directory and name slots to its end.
  function automatic void set_root(int unsigned r);
    offs[IX_ROOT] = r;
    offs[IX_DIR]  = r;
    offs[IX_BASE] = 0;
    offs[IX_EXT]  = r;
    offs[IX_NAME] = r;
    ph = PH_MAIN;
  endfunction

  // A dot only counts as an extension when a character follows it.
  function automatic void close_component(int unsigned p);
    offs[IX_NAME] = p;
    if (dot_seen && p - dot_pos >= 2) offs[IX_EXT] = dot_pos;
    else offs[IX_EXT] = p;
    in_comp = 1'b0;
  endfunction

  function automatic void main_byte(int unsigned p, cls_t c);
    if (c == CLS_SEP) begin
      if (in_comp) close_component(p);
      return;
    end
    if (!in_comp) begin
      offs[IX_DIR]  = offs[IX_NAME];
      offs[IX_BASE] = p;
      in_comp  = 1'b1;
      in_lead  = 1'b1;
      dot_seen = 1'b0;
    end
    // Leading dots of a component never start an extension.
    if (in_lead && c == CLS_DOT) return;
    in_lead = 1'b0;
    if (c == CLS_DOT) begin
      dot_pos  = p;
      dot_seen = 1'b1;
    end
  endfunction

  // Second byte did not open a drive or UNC root: settle on the first one.
  function automatic void short_root();
    if (first_cls == CLS_SEP) begin
      set_root(1);
    end else begin
      set_root(0);
      main_byte(0, first_cls);
    end
  endfunction

  function automatic void take_byte(logic [7:0] b);
    int unsigned p;
    cls_t        c;
    p = pos;
    c = classify(b);
    case (ph)
      PH_START: begin
        if (win_mode) begin
          first_cls = c;
          ph = PH_SECOND;
        end else if (c == CLS_SEP) begin
          set_root(1);
        end else begin
          set_root(0);
          main_byte(p, c);
        end
      end
      PH_SECOND: begin
        if (first_cls == CLS_SEP && c == CLS_SEP) begin
          ph = PH_UNC_SEPS;
        end else if (first_cls == CLS_ALPHA && b == CHR_COLON) begin
          ph = PH_DRIVE;
        end else begin
          short_root();
          main_byte(p, c);
        end
      end
      PH_DRIVE: begin
        if (c == CLS_SEP) begin
          set_root(p + 1);
        end else begin
          set_root(p);
          main_byte(p, c);
        end
      end
      PH_UNC_SEPS: begin
        if (c != CLS_SEP) ph = PH_UNC_NAME;
      end
      PH_UNC_NAME: begin
        if (c == CLS_SEP) set_root(p + 1);
      end
      default: begin
        main_byte(p, c);
      end
    endcase
    pos = p + 1;
  endfunction

  // One accepted input beat; the last beat of a path queues its offsets.
  function automatic void absorb_beat(logic [7:0] b, logic hb, logic lst);
    int unsigned  n;
    logic         need;
    logic [103:0] w;
    if (hb && !nul_seen && pos < POS_LIMIT) begin
      if (b == CHR_NUL) nul_seen = 1'b1;
      else take_byte(b);
    end
    if (!lst) return;
    n = pos;
    case (ph)
      PH_START:  set_root(0);
      PH_SECOND: short_root();
      PH_MAIN:   ;
      default:   set_root(n);
    endcase
    need = (n == 0) || (offs[IX_ROOT] != n && in_comp);
    if (in_comp) close_component(n);
    w = '0;
    for (int i = 0; i < 5; i++) w[i*16 +: 16] = offs[i][15:0];
    w[80 +: 16] = n[15:0];
    w[96]       = need;
    split_q.push_back(w);
    clear_path();
  endfunction

  function automatic logic [15:0] field_of(logic [103:0] w, int i);
    if (i < 6) return w[i*16 +: 16];
    if (i == 6) return {15'd0, w[96]};
    return {9'd0, w[103:97]};
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  function automatic void check_split(logic [103:0] got);
    logic [103:0] want;
    if (split_q.size() == 0) begin
      note_failure($sformatf("result beat with nothing expected, data %h", got));
      return;
    end
    want = split_q.pop_front();
    splits_checked++;
    for (int i = 0; i < 8; i++) begin
      if (field_of(want, i) !== field_of(got, i))
        note_failure($sformatf("%s expected %0d, got %0d", field_names[i],
                               field_of(want, i), field_of(got, i)));
    end
  endfunction

  // Input beats are taken before result beats so a path's offsets are queued
  // before its result could possibly be compared.
  always @(posedge clk) begin
    if (!rst_n) begin
      win_mode = 1'b0;
      clear_path();
      split_q.delete();
    end else begin
      if (in_tvalid && in_tready) absorb_beat(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) check_split(out_tdata);
      if (cfg_we) win_mode = cfg_wdata;
    end
    pending <= split_q.size();
  end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Path component splitter testbench
// Feeds the splitter short directed paths in both separator modes, then
// phases of random rooted paths with stray empty beats, zero bytes and noise,
// and a long result-side stall that backs up the input.
// The path checker predicts and compares; this module drives and decides.
// ----------------------------------------------------------------------------
module testbench;
  import psplit_pkg::*;

  typedef logic [7:0] byte_q_t [$];

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         cfg_we     = 1'b0;
  logic         cfg_wdata  = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = 8'd0;
  logic         in_tuser   = 1'b0;
  logic         in_tlast   = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;

  int fail_count;
  int pending;
  int splits_checked;
  int beats_sent = 0;
  int sink_stall = 0;
  bit tight      = 1'b0;  // no gaps on either side, no stray beats

  always #5 clk = ~clk;

  path_component_splitter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  path_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .splits_checked(splits_checked)
  );

  // Offers one beat after a random gap and holds it until it is taken.
  task automatic send_beat(input logic [7:0] b, input logic hb, input logic lst);
    int gap;
    gap = tight ? 0 : $urandom_range(0, 10);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= hb;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  // A path ends on its last byte, or on a separate empty beat when asked
  // (always so for the empty path).
  task automatic send_path(input byte_q_t path, input bit empty_tail);
    int n;
    n = path.size();
    for (int i = 0; i < n; i++) begin
      if (!tight && $urandom_range(0, 11) == 0)
        send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_beat(path[i], 1'b1, (i == n - 1) && !empty_tail);
    end
    if (n == 0 || empty_tail) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Stops offering beats and waits for every outstanding result.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    @(negedge clk);
    cfg_wdata <= m;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic byte_q_t to_bytes(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic logic [7:0] random_sep();
    return $urandom_range(0, 1) ? CHR_SLASH : CHR_BACKSLASH;
  endfunction

  function automatic logic [7:0] random_name_char();
    case ($urandom_range(0, 9))
      0, 1:    return 8'("a" + $urandom_range(0, 25));
      2, 3:    return 8'("A" + $urandom_range(0, 25));
      4, 5:    return CHR_DOT;
      6:       return CHR_COLON;
      7:       return 8'("0" + $urandom_range(0, 9));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic byte_q_t random_word(int max_len);
    byte_q_t w;
    repeat ($urandom_range(0, max_len)) w.push_back(random_name_char());
    return w;
  endfunction

  // Mostly rooted paths with short components; a fifth is plain noise.
  function automatic byte_q_t random_path();
    byte_q_t p;
    int      comps;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(0, 8)) p.push_back(8'($urandom_range(0, 255)));
      return p;
    end
    case ($urandom_range(0, 6))
      0: ;
      1: p.push_back(random_sep());
      2: begin
        p.push_back(random_sep());
        p.push_back(random_sep());
        p = {p, random_word(4)};
        p.push_back(random_sep());
      end
      3, 4: begin
        p.push_back($urandom_range(0, 3) == 0 ? random_name_char() :
                    8'("C" + $urandom_range(0, 3)));
        p.push_back(CHR_COLON);
        if ($urandom_range(0, 1)) p.push_back(random_sep());
      end
      5: begin
        p.push_back(random_sep());
        p.push_back(random_sep());
        p.push_back(random_sep());
      end
      default: p.push_back(random_name_char());
    endcase
    comps = $urandom_range(0, 4);
    for (int c = 0; c < comps; c++) begin
      p = {p, random_word(6)};
      if (c < comps - 1 || $urandom_range(0, 3) == 0) p.push_back(random_sep());
    end
    // A zero byte somewhere ends the path early.
    if (p.size() > 0 && $urandom_range(0, 9) == 0)
      p.insert($urandom_range(0, p.size() - 1), CHR_NUL);
    return p;
  endfunction

  // Result side: random hold-offs, or one long stall when asked for.
  initial begin : result_sink
    int wait_cycles;
    forever begin
      @(negedge clk);
      if (sink_stall > 0) begin
        wait_cycles = sink_stall;
        sink_stall  = 0;
      end else begin
        wait_cycles = tight ? 0 : $urandom_range(0, 10);
      end
      if (wait_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : watchdog
    #1_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    byte_q_t path;
    int      phase_start;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed, forward slash only: empty path, bare root, leading and
    // inner dots, trailing separator, a zero byte cutting the path.
    set_mode(1'b0);
    send_path(path, 1'b0);
    send_path(to_bytes("/"), 1'b0);
    send_path(to_bytes(".a.b"), 1'b0);
    send_path(to_bytes("x/"), 1'b0);
    path = '{8'hFF, CHR_NUL, CHR_SLASH};
    send_path(path, 1'b0);
    drain();

    // Directed, Windows roots: drive with separator, UNC, bare drive, bare
    // backslash.
    set_mode(1'b1);
    send_path(to_bytes("C:\\a"), 1'b0);
    send_path(to_bytes("\\\\s\\t"), 1'b0);
    send_path(to_bytes("c:"), 1'b0);
    send_path(to_bytes("\\"), 1'b0);

    // Random phases, each starting from an idle block with a fresh mode.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      set_mode(ph == 0 ? 1'b0 : ph == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
      tight = (ph % 3 == 2);
      if (ph == 4) begin
        // Back-to-back one-byte paths against a stalled result side.
        tight      = 1'b1;
        sink_stall = 300;
        repeat (24) begin
          path = '{random_name_char()};
          send_path(path, 1'b0);
        end
        tight = 1'b0;
      end
      phase_start = beats_sent;
      while (beats_sent - phase_start < 40)
        send_path(random_path(), $urandom_range(0, 4) == 0);
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d beats: directed roots, random paths in both modes.", beats_sent);
    $display("Checked %0d split results, %0d mismatches.", splits_checked, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### files.f
sv/psplit_pkg.sv
sv/psplit_front.sv
sv/psplit_queue.sv
sv/psplit_back.sv
sv/path_component_splitter.sv
sv/psplit_checker.sv
verif/path_checker.sv
verif/testbench.sv
